@@ design/bpbp_pkg.sv @@
`default_nettype none
package bpbp_pkg;

  localparam int unsigned PosW        = 32;
  localparam int unsigned MaxCodeBits = 32;
  localparam int unsigned CntW        = 6;
  // bit buffer: up to seven leftover bits plus one full code
  localparam int unsigned BufW        = 40;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    RegSelect = 3'd0,
    RegStart  = 3'd1,
    RegBase   = 3'd2,
    RegEnd    = 3'd3,
    RegWidth  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic            select_clear;
    logic [PosW-1:0] base_offset;
    logic [PosW-1:0] end_pos;
  } cfg_t;

  // one scanned bitmap bit; eoi closes the input byte it came from
  typedef struct packed {
    logic            has_code;
    logic [PosW-1:0] code;
    logic            eoi;
    logic            fin;
  } entry_t;

endpackage
`default_nettype wire

@@ design/bitmap_position_bit_packer_unit.sv @@
// bitmap position bit packer
// input channel: one bitmap byte per transaction (map_byte_i, bit 7 is the
// lowest position) and final_byte_i, which closes the stream. output channel:
// one packed byte per transaction, with run_last_o on the last byte caused by
// an input byte and stream_end_o on the last byte of a final input.
// both channels move a transaction on a clock edge with valid high and stall
// low. configuration is written over the apb port; the user must write it
// only while the unit is idle, the unit itself does not enforce this.
// the front scans one bitmap bit per cycle while the queue is not full, and
// a new input byte is taken in the same cycle its last bit is queued. the
// back packs one queued bit or emits one byte per cycle while the output is
// not stalled, and closes each input in a step of its own (after a padded
// flush step on a final input with a partial byte); wide codes take a step
// for each further output byte. a 4-entry queue lets the two run apart.
// a completed byte passes through a hold register and then the output
// register; the last byte of an input moves on when the back closes that input.
// reset clears the registers (code width 8), the position counter and the
// partial byte. a stalled output holds its byte; the back and then the queue
// and the front fill up and in_stall_o rises.
`default_nettype none
module bitmap_position_bit_packer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  map_byte_i,
  input  wire logic        final_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       packed_byte_o,
  output logic             run_last_o,
  output logic             stream_end_o
);

  localparam int unsigned PosW = bpbp_pkg::PosW;
  localparam int unsigned CntW = bpbp_pkg::CntW;

  logic                sel_q;
  logic [PosW-1:0]     start_q;
  logic [PosW-1:0]     base_q;
  logic [PosW-1:0]     endp_q;
  logic [CntW-1:0]     cw_q;
  logic [CntW-1:0]     width_eff;
  logic                wr_en;
  logic                start_load;
  bpbp_pkg::reg_idx_e  reg_idx;
  bpbp_pkg::cfg_t      cfg;
  logic                in_ready;
  logic                push, pop, full, empty;
  bpbp_pkg::entry_t    push_entry, head;

  assign pready     = 1'b1;
  assign wr_en      = psel && penable && pwrite;
  assign reg_idx    = bpbp_pkg::reg_idx_e'(paddr[4:2]);
  assign start_load = wr_en && reg_idx == bpbp_pkg::RegStart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      start_q <= '0;
      base_q  <= '0;
      endp_q  <= '0;
      cw_q    <= CntW'(8);
    end else if (wr_en) begin
      case (reg_idx)
        bpbp_pkg::RegSelect: sel_q   <= pwdata[0];
        bpbp_pkg::RegStart:  start_q <= pwdata;
        bpbp_pkg::RegBase:   base_q  <= pwdata;
        bpbp_pkg::RegEnd:    endp_q  <= pwdata;
        bpbp_pkg::RegWidth:  cw_q    <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpbp_pkg::RegSelect: prdata = {31'b0, sel_q};
      bpbp_pkg::RegStart:  prdata = start_q;
      bpbp_pkg::RegBase:   prdata = base_q;
      bpbp_pkg::RegEnd:    prdata = endp_q;
      bpbp_pkg::RegWidth:  prdata = {{(32-CntW){1'b0}}, cw_q};
      default:             prdata = '0;
    endcase
  end

  // zero width codes as one bit, wide ones are capped
  always_comb begin
    if (cw_q == '0) begin
      width_eff = CntW'(1);
    end else if (cw_q > CntW'(bpbp_pkg::MaxCodeBits)) begin
      width_eff = CntW'(bpbp_pkg::MaxCodeBits);
    end else begin
      width_eff = cw_q;
    end
  end

  always_comb begin
    cfg.select_clear = sel_q;
    cfg.base_offset  = base_q;
    cfg.end_pos      = endp_q;
  end

  assign in_stall_o = !in_ready;

  bpbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .start_load_i  (start_load),
    .start_value_i (pwdata),
    .start_pos_i   (start_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready),
    .map_byte_i    (map_byte_i),
    .final_byte_i  (final_byte_i),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  bpbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  bpbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .width_i       (width_eff),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_byte_o (packed_byte_o),
    .run_last_o    (run_last_o),
    .stream_end_o  (stream_end_o)
  );

endmodule
`default_nettype wire

@@ design/bpbp_fifo.sv @@
`default_nettype none
module bpbp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bpbp_pkg::entry_t entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output bpbp_pkg::entry_t     head_o,
  output logic                 empty_o
);

  bpbp_pkg::entry_t mem_q [bpbp_pkg::QueueDepth];
  logic [bpbp_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [bpbp_pkg::QueuePtrW:0]   cnt_q;

  assign full_o  = cnt_q == (bpbp_pkg::QueuePtrW+1)'(bpbp_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/bpbp_front.sv @@
`default_nettype none
module bpbp_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bpbp_pkg::cfg_t            cfg_i,
  input  wire logic                      start_load_i,
  input  wire logic [bpbp_pkg::PosW-1:0] start_value_i,
  input  wire logic [bpbp_pkg::PosW-1:0] start_pos_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                map_byte_i,
  input  wire logic                      final_byte_i,
  output logic                           push_o,
  output bpbp_pkg::entry_t               entry_o,
  input  wire logic                      full_i
);

  logic                      busy_q;
  logic [2:0]                idx_q;
  logic [7:0]                map_q;
  logic                      final_q;
  logic [bpbp_pkg::PosW:0]   pos_q;
  logic                      last_bit;
  logic                      selected;
  logic                      in_range;
  logic                      accept;

  assign last_bit   = idx_q == 3'd7;
  assign push_o     = busy_q && !full_i;
  assign in_ready_o = !busy_q || (last_bit && !full_i);
  assign accept     = in_valid_i && in_ready_o;

  // bit 7 of the map byte is the lowest position
  assign selected = map_q[3'd7 - idx_q] ^ cfg_i.select_clear;
  assign in_range = (pos_q >= {1'b0, cfg_i.base_offset}) &&
                    (pos_q <= {1'b0, cfg_i.end_pos});

  always_comb begin
    entry_o.has_code = selected && in_range;
    entry_o.code     = pos_q[bpbp_pkg::PosW-1:0] - cfg_i.base_offset;
    entry_o.eoi      = last_bit;
    entry_o.fin      = last_bit && final_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      map_q   <= '0;
      final_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (start_load_i) begin
        pos_q <= {1'b0, start_value_i};
      end
      if (push_o) begin
        idx_q <= idx_q + 1'b1;
        // saturate at the top of the position space
        if (!pos_q[bpbp_pkg::PosW]) begin
          pos_q <= pos_q + 1'b1;
        end
        if (last_bit) begin
          busy_q <= 1'b0;
          if (final_q) begin
            pos_q <= {1'b0, start_pos_i};
          end
        end
      end
      if (accept) begin
        busy_q  <= 1'b1;
        idx_q   <= '0;
        map_q   <= map_byte_i;
        final_q <= final_byte_i;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/bpbp_back.sv @@
`default_nettype none
module bpbp_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [bpbp_pkg::CntW-1:0] width_i,
  input  wire bpbp_pkg::entry_t          head_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [7:0]                     packed_byte_o,
  output logic                           run_last_o,
  output logic                           stream_end_o
);

  localparam int unsigned BufW = bpbp_pkg::BufW;
  localparam int unsigned CntW = bpbp_pkg::CntW;
  localparam int unsigned PosW = bpbp_pkg::PosW;

  logic [BufW-1:0] buf_q, buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            eoi_q, eoi_d;
  logic            fin_q, fin_d;
  logic            hold_valid_q, hold_valid_d;
  logic [7:0]      hold_q, hold_d;
  logic            o_valid_q, o_valid_d;
  logic [7:0]      o_byte_q, o_byte_d;
  logic            o_last_q, o_last_d;
  logic            o_end_q, o_end_d;

  logic            adv;
  logic            produce;
  logic [7:0]      pbyte;
  logic [PosW-1:0] code_l;
  logic [BufW-1:0] merged;
  logic [CntW-1:0] total;

  assign adv = !o_valid_q || !out_stall_i;

  // code left-aligned, then placed after the leftover bits
  assign code_l = head_i.code << (CntW'(PosW) - width_i);
  assign merged = buf_q | ({code_l, 8'b0} >> cnt_q[2:0]);
  assign total  = cnt_q + width_i;

  always_comb begin
    buf_d        = buf_q;
    cnt_d        = cnt_q;
    eoi_d        = eoi_q;
    fin_d        = fin_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    o_valid_d    = o_valid_q && out_stall_i;
    o_byte_d     = o_byte_q;
    o_last_d     = o_last_q;
    o_end_d      = o_end_q;
    pop_o        = 1'b0;
    produce      = 1'b0;
    pbyte        = buf_q[BufW-1 -: 8];
    if (adv) begin
      if (cnt_q >= CntW'(8)) begin
        produce = 1'b1;
        buf_d   = buf_q << 8;
        cnt_d   = cnt_q - CntW'(8);
      end else if (eoi_q) begin
        if (fin_q && cnt_q != '0) begin
          // padded flush of the partial byte
          produce = 1'b1;
          buf_d   = '0;
          cnt_d   = '0;
        end else begin
          eoi_d = 1'b0;
          if (hold_valid_q) begin
            o_valid_d    = 1'b1;
            o_byte_d     = hold_q;
            o_last_d     = 1'b1;
            o_end_d      = fin_q;
            hold_valid_d = 1'b0;
          end
        end
      end else if (!empty_i) begin
        pop_o = 1'b1;
        eoi_d = head_i.eoi;
        fin_d = head_i.fin;
        if (head_i.has_code) begin
          if (total >= CntW'(8)) begin
            produce = 1'b1;
            pbyte   = merged[BufW-1 -: 8];
            buf_d   = merged << 8;
            cnt_d   = total - CntW'(8);
          end else begin
            buf_d = merged;
            cnt_d = total;
          end
        end
      end
    end
    // a byte waits in hold until it is known whether it ends its input
    if (produce) begin
      if (hold_valid_q) begin
        o_valid_d = 1'b1;
        o_byte_d  = hold_q;
        o_last_d  = 1'b0;
        o_end_d   = 1'b0;
      end
      hold_d       = pbyte;
      hold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q        <= '0;
      cnt_q        <= '0;
      eoi_q        <= 1'b0;
      fin_q        <= 1'b0;
      hold_valid_q <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      buf_q        <= buf_d;
      cnt_q        <= cnt_d;
      eoi_q        <= eoi_d;
      fin_q        <= fin_d;
      hold_valid_q <= hold_valid_d;
      o_valid_q    <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q   <= hold_d;
    o_byte_q <= o_byte_d;
    o_last_q <= o_last_d;
    o_end_q  <= o_end_d;
  end

  assign out_valid_o   = o_valid_q;
  assign packed_byte_o = o_byte_q;
  assign run_last_o    = o_last_q;
  assign stream_end_o  = o_end_q;

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(39))
    else $error("bit buffer count out of range");

  a_pop_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!eoi_q && cnt_q < CntW'(8)))
    else $error("queue popped while bytes or end of input pending");

  a_final_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($fell(eoi_q) && $past(fin_q)) |-> (cnt_q == '0 && !hold_valid_q))
    else $error("bits left over after end of stream");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_end_q) |-> o_last_q)
    else $error("stream end without run last");

endmodule
`default_nettype wire
